/* hw/rtl/gpcpp_pkg.sv */
// Shared types, phase codes and the presence search for the commissioning parser.
`default_nettype none

package gpcpp_pkg;

  localparam int unsigned KEY_BYTES = 16;

  // Parse phase codes, one per payload field, then the finished phase.
  localparam logic [3:0] PH_DEVICE   = 4'd0;
  localparam logic [3:0] PH_OPTS     = 4'd1;
  localparam logic [3:0] PH_EXT      = 4'd2;
  localparam logic [3:0] PH_KEY      = 4'd3;
  localparam logic [3:0] PH_MIC      = 4'd4;
  localparam logic [3:0] PH_COUNTER  = 4'd5;
  localparam logic [3:0] PH_APP      = 4'd6;
  localparam logic [3:0] PH_MANUF    = 4'd7;
  localparam logic [3:0] PH_MODEL    = 4'd8;
  localparam logic [3:0] PH_CMDCOUNT = 4'd9;
  localparam logic [3:0] PH_CMD      = 4'd10;
  localparam logic [3:0] PH_CLUSTER  = 4'd11;
  localparam logic [3:0] PH_END      = 4'd12;

  typedef struct packed {
    logic [3:0]  phase;
    logic [4:0]  byte_in_field;
    logic [7:0]  options_seen;
    logic [7:0]  ext_options_seen;
    logic [7:0]  app_info_seen;
    logic [31:0] value_accumulator;
    logic [7:0]  commands_left;
  } gpcpp_state_t;

  typedef struct packed {
    logic        field_valid;
    logic [3:0]  field_kind;
    logic [31:0] field_value;
    logic        done_res;
    logic        truncated;
  } gpcpp_res_t;

  localparam gpcpp_state_t STATE_RESET = '{
    phase: PH_DEVICE, byte_in_field: 5'd0, options_seen: 8'd0,
    ext_options_seen: 8'd0, app_info_seen: 8'd0,
    value_accumulator: 32'd0, commands_left: 8'd0
  };

  // First phase at or after start whose field is announced; PH_END if none.
  function automatic logic [3:0] next_phase(
    input logic [3:0] start,
    input logic [7:0] opts,
    input logic [7:0] ext,
    input logic [7:0] app,
    input logic [7:0] cmds
  );
    logic [12:0] present;
    logic [3:0]  res;
    logic        found;
    present              = '1;
    present[PH_EXT]      = opts[7];
    present[PH_KEY]      = ext[5];
    present[PH_MIC]      = ext[5] & ext[6];
    present[PH_COUNTER]  = ext[7];
    present[PH_APP]      = opts[2];
    present[PH_MANUF]    = app[0];
    present[PH_MODEL]    = app[1];
    present[PH_CMDCOUNT] = app[2];
    present[PH_CMD]      = (cmds != 8'd0);
    present[PH_CLUSTER]  = app[3];
    res   = PH_END;
    found = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (!found && (4'(i) >= start) && present[i]) begin
        res   = 4'(i);
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/gpcpp_step.sv */
// Per-byte parse step: next parser state and the result for one payload byte.
`default_nettype none

module gpcpp_step (
  input  gpcpp_pkg::gpcpp_state_t st,
  input  logic [7:0]              msg_byte,
  input  logic                    last_byte,
  output gpcpp_pkg::gpcpp_state_t st_next,
  output gpcpp_pkg::gpcpp_res_t   res
);
  import gpcpp_pkg::*;

  logic [4:0]  bif_inc;
  logic [4:0]  need;
  logic [31:0] acc_or;
  logic [7:0]  cmds_dec;
  gpcpp_state_t upd;

  assign bif_inc  = st.byte_in_field + 5'd1;
  assign need     = ((st.phase == PH_MIC) || (st.phase == PH_COUNTER)) ? 5'd4 : 5'd2;
  assign acc_or   = st.value_accumulator
                  | ({24'd0, msg_byte} << {st.byte_in_field[1:0], 3'b000});
  assign cmds_dec = st.commands_left - 8'd1;

  always_comb begin
    upd             = st;
    res.field_valid = 1'b0;
    res.field_kind  = 4'd0;
    res.field_value = 32'd0;
    case (st.phase)
      PH_DEVICE: begin
        res.field_valid = 1'b1;
        res.field_kind  = st.phase;
        res.field_value = {24'd0, msg_byte};
        upd.phase       = PH_OPTS;
      end
      PH_OPTS: begin
        upd.options_seen = msg_byte;
        res.field_valid  = 1'b1;
        res.field_kind   = st.phase;
        res.field_value  = {24'd0, msg_byte};
        upd.phase = next_phase(PH_EXT, msg_byte, st.ext_options_seen,
                               st.app_info_seen, st.commands_left);
      end
      PH_EXT: begin
        upd.ext_options_seen = msg_byte;
        res.field_valid      = 1'b1;
        res.field_kind       = st.phase;
        res.field_value      = {24'd0, msg_byte};
        upd.phase = next_phase(PH_KEY, st.options_seen, msg_byte,
                               st.app_info_seen, st.commands_left);
      end
      PH_KEY: begin
        res.field_valid   = 1'b1;
        res.field_kind    = st.phase;
        res.field_value   = {24'd0, msg_byte};
        upd.byte_in_field = bif_inc;
        if (bif_inc >= 5'(KEY_BYTES)) begin
          upd.byte_in_field = 5'd0;
          upd.phase = next_phase(PH_MIC, st.options_seen, st.ext_options_seen,
                                 st.app_info_seen, st.commands_left);
        end
      end
      PH_MIC, PH_COUNTER, PH_MANUF, PH_MODEL: begin
        upd.value_accumulator = acc_or;
        upd.byte_in_field     = bif_inc;
        if (bif_inc >= need) begin
          res.field_valid       = 1'b1;
          res.field_kind        = st.phase;
          res.field_value       = acc_or;
          upd.value_accumulator = 32'd0;
          upd.byte_in_field     = 5'd0;
          upd.phase = next_phase(st.phase + 4'd1, st.options_seen,
                                 st.ext_options_seen, st.app_info_seen,
                                 st.commands_left);
        end
      end
      PH_APP: begin
        upd.app_info_seen = msg_byte;
        res.field_valid   = 1'b1;
        res.field_kind    = st.phase;
        res.field_value   = {24'd0, msg_byte};
        upd.phase = next_phase(PH_MANUF, st.options_seen, st.ext_options_seen,
                               msg_byte, st.commands_left);
      end
      PH_CMDCOUNT: begin
        upd.commands_left = msg_byte;
        res.field_valid   = 1'b1;
        res.field_kind    = st.phase;
        res.field_value   = {24'd0, msg_byte};
        upd.phase = next_phase(PH_CMD, st.options_seen, st.ext_options_seen,
                               st.app_info_seen, msg_byte);
      end
      PH_CMD: begin
        res.field_valid   = 1'b1;
        res.field_kind    = st.phase;
        res.field_value   = {24'd0, msg_byte};
        upd.commands_left = cmds_dec;
        if (cmds_dec == 8'd0) begin
          upd.phase = next_phase(PH_CLUSTER, st.options_seen, st.ext_options_seen,
                                 st.app_info_seen, cmds_dec);
        end
      end
      PH_CLUSTER: begin
        res.field_valid = 1'b1;
        res.field_kind  = st.phase;
        res.field_value = {24'd0, msg_byte};
      end
      default: begin
        // finished or unused phase: trailing bytes are ignored
      end
    endcase

    res.done_res  = last_byte;
    res.truncated = last_byte && (upd.phase < PH_CLUSTER);
    st_next       = last_byte ? STATE_RESET : upd;
  end

endmodule

`default_nettype wire

/* hw/rtl/gp_commissioning_payload_parser.sv */
// Top level of the commissioning payload parser: input stage, parse state, result register.
//
// Usage:
//   Slave channel s_*: one payload byte per request, s_tlast on the final byte
//   of a message. Master channel m_*: exactly one result per byte, m_tlast
//   copies the byte's s_tlast (done_res).
//   A result says whether a field completed with that byte (m_tuser[0]), which
//   field (m_tuser[4:1]), and its value on m_tdata (multi-byte fields
//   little-endian). On the last byte, m_tuser[5] flags a message that ended
//   inside an announced field; the cluster list is open-ended, so ending there
//   is not truncation.
//   Path: an accepted byte is held in the input register, then the parse step
//   writes its result into the result register.
//   Throughput: one byte per cycle while results are taken, set by the combinational
//   parse step that updates the phase, byte counter, flag copies and accumulator.
//   Stall: when m_tready is low the result register holds; the input stage
//   holds one more byte, after which s_tready drops until the result drains.
//   Reset (rst, synchronous): both stages empty, parser back to expecting the
//   device id. After every last byte the parser state returns there as well.
`default_nettype none

module gp_commissioning_payload_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] field_value
  output logic [5:0]  m_tuser,   // [0] field_valid, [4:1] field_kind, [5] truncated
  output logic        m_tlast    // done_res
);
  import gpcpp_pkg::*;

  // input stage
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // parse state
  gpcpp_state_t st;
  gpcpp_state_t st_next;
  gpcpp_res_t   res;

  logic advance;

  // stage 1 moves into the result register when that register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  gpcpp_step u_step (
    .st        (st),
    .msg_byte  (in_byte),
    .last_byte (in_last),
    .st_next   (st_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= res.field_value;
      m_tuser <= {res.truncated, res.field_kind, res.field_valid};
      m_tlast <= res.done_res;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gpcpp_checker.sv */
// Port-level checks for the commissioning payload parser, bound to the top level.
`default_nettype none

module gpcpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [5:0]  m_tuser,
  input logic        m_tlast
);
  import gpcpp_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  // with the result register empty the input side takes a request
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input not ready with empty result register");

  // no completed field means kind and value are zero
  a_nofield: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tuser[4:1] == 4'd0 && m_tdata == 32'd0)
    else $error("kind/value nonzero without a field");

  // field kind stays within the defined fields
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[4:1] <= PH_CLUSTER)
    else $error("field kind out of range");

  // truncation only reported on the last byte
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tuser[5])
    else $error("truncated outside last byte");

endmodule

bind gp_commissioning_payload_parser gpcpp_checker u_gpcpp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

/* verif/tb.sv */
// Testbench for the commissioning payload parser: directed table, random messages, predictor.
`timescale 1ns / 100ps

module tb;
  import gpcpp_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] msg_byte
  logic        s_tlast  = 1'b0;   // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] field_value
  logic [5:0]  m_tuser;           // [0] field_valid, [4:1] field_kind, [5] truncated
  logic        m_tlast;           // done_res

  gp_commissioning_payload_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // Directed table row; when known is set, want is the literal expectation,
  // otherwise the predictor decides.
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last;
    logic       known;
    gpcpp_res_t want;
  } dir_row_t;

  localparam int N_DIRECTED = 24;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // one-byte message: device id only, ends inside the options field
    '{8'hFF, 1'b1, 1'b1, '{1'b1, PH_DEVICE, 32'h0000_00FF, 1'b1, 1'b1}},
    // options announce nothing: parse finishes, trailing byte is ignored
    '{8'h00, 1'b0, 1'b1, '{1'b1, PH_DEVICE, 32'h0, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{1'b1, PH_OPTS, 32'h0, 1'b0, 1'b0}},
    '{8'h5A, 1'b1, 1'b1, '{1'b0, 4'd0, 32'h0, 1'b1, 1'b0}},
    // app info with manuf, model, zero command count, one cluster byte
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0},
    '{8'h0F, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hAB, 1'b1, 1'b0, '0},
    // ext opts with counter only; message stops after 3 counter bytes
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, '0},
    '{8'hBE, 1'b0, 1'b0, '0},
    '{8'hAD, 1'b1, 1'b1, '{1'b0, 4'd0, 32'h0, 1'b1, 1'b1}},
    // one command, then end with the cluster list open but empty
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0},
    '{8'h0C, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'hC3, 1'b1, 1'b0, '0}
  };

  // ---------------------------------------------------------------- predictor
  logic [3:0]  prs_phase;
  logic [4:0]  prs_count;
  logic [7:0]  prs_opts;
  logic [7:0]  prs_ext;
  logic [7:0]  prs_app;
  logic [31:0] prs_acc;
  logic [7:0]  prs_cmds;

  function automatic void parser_clear();
    prs_phase = PH_DEVICE;
    prs_count = '0;
    prs_opts  = '0;
    prs_ext   = '0;
    prs_app   = '0;
    prs_acc   = '0;
    prs_cmds  = '0;
  endfunction

  function automatic logic field_announced(input logic [3:0] ph);
    case (ph)
      PH_EXT:      return prs_opts[7];
      PH_KEY:      return prs_ext[5];
      PH_MIC:      return prs_ext[5] & prs_ext[6];
      PH_COUNTER:  return prs_ext[7];
      PH_APP:      return prs_opts[2];
      PH_MANUF:    return prs_app[0];
      PH_MODEL:    return prs_app[1];
      PH_CMDCOUNT: return prs_app[2];
      PH_CMD:      return prs_cmds != 8'd0;
      PH_CLUSTER:  return prs_app[3];
      default:     return 1'b1;
    endcase
  endfunction

  function automatic logic [3:0] first_announced(input logic [3:0] start);
    logic [3:0] ph;
    ph = start;
    while (ph < PH_END && !field_announced(ph)) ph = ph + 4'd1;
    return ph;
  endfunction

  // Parse one byte; returns the result the block must give for it.
  function automatic gpcpp_res_t payload_step(input logic [7:0] b, input logic l);
    gpcpp_res_t r;
    logic [3:0] ph;
    logic       hit;
    logic [31:0] v;
    logic [4:0] need;
    r   = '0;
    ph  = prs_phase;
    hit = 1'b0;
    v   = {24'd0, b};
    case (ph)
      PH_DEVICE: begin
        hit = 1'b1;
        prs_phase = PH_OPTS;
      end
      PH_OPTS: begin
        prs_opts = b;
        hit = 1'b1;
        prs_phase = first_announced(PH_EXT);
      end
      PH_EXT: begin
        prs_ext = b;
        hit = 1'b1;
        prs_phase = first_announced(PH_KEY);
      end
      PH_KEY: begin
        hit = 1'b1;
        prs_count = prs_count + 5'd1;
        if (prs_count >= KEY_BYTES) begin
          prs_count = '0;
          prs_phase = first_announced(PH_MIC);
        end
      end
      PH_MIC, PH_COUNTER, PH_MANUF, PH_MODEL: begin
        need = (ph == PH_MIC || ph == PH_COUNTER) ? 5'd4 : 5'd2;
        prs_acc = prs_acc | ({24'd0, b} << (8 * prs_count[1:0]));
        prs_count = prs_count + 5'd1;
        if (prs_count >= need) begin
          hit = 1'b1;
          v = prs_acc;
          prs_acc = '0;
          prs_count = '0;
          prs_phase = first_announced(ph + 4'd1);
        end
      end
      PH_APP: begin
        prs_app = b;
        hit = 1'b1;
        prs_phase = first_announced(PH_MANUF);
      end
      PH_CMDCOUNT: begin
        prs_cmds = b;
        hit = 1'b1;
        prs_phase = first_announced(PH_CMD);
      end
      PH_CMD: begin
        hit = 1'b1;
        prs_cmds = prs_cmds - 8'd1;
        if (prs_cmds == 8'd0) prs_phase = first_announced(PH_CLUSTER);
      end
      PH_CLUSTER: begin
        hit = 1'b1;
      end
      default: ;  // finished: byte ignored
    endcase
    if (hit) begin
      r.field_valid = 1'b1;
      r.field_kind  = ph;
      r.field_value = v;
    end
    r.done_res = l;
    if (l) begin
      r.truncated = (prs_phase < PH_CLUSTER);
      parser_clear();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- scoreboard
  gpcpp_res_t pending_fields[$];
  int         mismatches = 0;
  int         fed_bytes  = 0;
  bit         full_speed = 1'b0;
  logic [7:0] msg_q[$];

  // queue helpers: append at the tail
  function automatic void expect_result(input gpcpp_res_t r);
    pending_fields.insert(pending_fields.size(), r);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sink side: random ready pattern, and score every accepted result.
  int rdy_hold = 0;
  always @(posedge clk) begin
    gpcpp_res_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_fields.size() == 0) begin
          report_mismatch("result with nothing pending", m_tdata, 32'h0);
        end else begin
          want = pending_fields.pop_front();
          if (m_tuser[0] !== want.field_valid)
            report_mismatch("field_valid", {31'd0, m_tuser[0]}, {31'd0, want.field_valid});
          if (m_tuser[4:1] !== want.field_kind)
            report_mismatch("field_kind", {28'd0, m_tuser[4:1]}, {28'd0, want.field_kind});
          if (m_tdata !== want.field_value)
            report_mismatch("field_value", m_tdata, want.field_value);
          if (m_tlast !== want.done_res)
            report_mismatch("done_res", {31'd0, m_tlast}, {31'd0, want.done_res});
          if (m_tuser[5] !== want.truncated)
            report_mismatch("truncated", {31'd0, m_tuser[5]}, {31'd0, want.truncated});
        end
      end
      if (rdy_hold != 0) begin
        rdy_hold <= rdy_hold - 1;
      end else if (full_speed || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        rdy_hold <= $urandom_range(0, 8);
      end else begin
        m_tready <= 1'b0;
        rdy_hold <= pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- source side
  // Offer one byte, wait for the request to be taken, return the prediction.
  task automatic offer_byte(input logic [7:0] b, input logic l, output gpcpp_res_t want);
    int gap;
    gap = full_speed ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (prs_phase < PH_END) fed_bytes++;
    want = payload_step(b, l);
  endtask

  // Build one message: mostly well formed with random content, some cut
  // short, some with trailing junk, some plain noise.
  task automatic make_message();
    logic [7:0] opts;
    logic [7:0] ext;
    logic [7:0] app;
    logic [7:0] cnt;
    int mode;
    int keep;
    msg_q.delete();
    opts = 8'($urandom);
    ext  = 8'($urandom);
    app  = 8'($urandom);
    if ($urandom_range(0, 3) != 0) opts[7] = 1'b1;
    if ($urandom_range(0, 3) != 0) opts[2] = 1'b1;
    if ($urandom_range(0, 2) != 0) ext[5] = 1'b1;
    add_byte(8'($urandom));
    add_byte(opts);
    if (opts[7]) begin
      add_byte(ext);
      if (ext[5]) repeat (KEY_BYTES) add_byte(8'($urandom));
      if (ext[5] && ext[6]) repeat (4) add_byte(8'($urandom));
      if (ext[7]) repeat (4) add_byte(8'($urandom));
    end
    if (opts[2]) begin
      add_byte(app);
      if (app[0]) repeat (2) add_byte(8'($urandom));
      if (app[1]) repeat (2) add_byte(8'($urandom));
      if (app[2]) begin
        // an occasional full-range count, mostly a handful of commands
        cnt = ($urandom_range(0, 24) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        add_byte(cnt);
        repeat (cnt) add_byte(8'($urandom));
      end
      if (app[3]) repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
    end
    mode = $urandom_range(0, 19);
    if (mode < 3) begin
      keep = $urandom_range(1, msg_q.size());
      while (msg_q.size() > keep) void'(msg_q.pop_back());
    end else if (mode < 5) begin
      msg_q.delete();
      repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
    end else if (mode < 8) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
    end
  endtask

  initial begin
    gpcpp_res_t want;
    int msg_count;
    parser_clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_byte(DIRECTED[i].msg_byte, DIRECTED[i].last, want);
      expect_result(DIRECTED[i].known ? DIRECTED[i].want : want);
    end

    // random messages
    msg_count = 0;
    while (fed_bytes < 2000) begin
      make_message();
      full_speed = (msg_count % 8 == 7);
      if (msg_count % 40 == 20) begin
        // hold the source until everything in flight has come back
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_fields.size() != 0) @(posedge clk);
      end
      for (int i = 0; i < msg_q.size(); i++) begin
        offer_byte(msg_q[i], i == msg_q.size() - 1, want);
        expect_result(want);
      end
      msg_count++;
    end
    full_speed = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_fields.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
